// ===== src/cfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants for the control frame deframer.
// ----------------------------------------------------------------------------
package cfd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  // shortest legal frame: two sync bytes, length, one data byte, checksum
  localparam logic [BYTE_W-1:0] MIN_FRAME_LENGTH = 8'd5;

  // fixed header positions
  localparam logic [BYTE_W-1:0] POS_HDR1 = 8'd0;
  localparam logic [BYTE_W-1:0] POS_HDR2 = 8'd1;
  localparam logic [BYTE_W-1:0] POS_LEN  = 8'd2;
  localparam logic [BYTE_W-1:0] POS_DATA = 8'd3;

  // register indexes (paddr[3:2])
  typedef enum logic [1:0] {
    REG_HEADER_FIRST  = 2'd0,
    REG_HEADER_SECOND = 2'd1,
    REG_MAX_LENGTH    = 2'd2,
    REG_UNUSED        = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_HDR2 = 2'd1,
    PH_LEN  = 2'd2,
    PH_DATA = 2'd3
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_IGNORED = 3'd0,
    ST_BYTE    = 3'd1,
    ST_GOOD    = 3'd2,
    ST_BAD     = 3'd3,
    ST_ABORT   = 3'd4
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] header_first;
    logic [BYTE_W-1:0] header_second;
    logic [BYTE_W-1:0] max_frame_length;
  } cfg_regs_t;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] byte_position;
    status_t           status;
  } result_t;

endpackage

// ===== src/cfd_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_regs
// APB-style configuration registers: sync bytes and maximum frame length.
// ----------------------------------------------------------------------------
module cfd_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [cfd_pkg::CFG_ADDR_W-1:0]      cfg_paddr,
  input  logic [cfd_pkg::CFG_DATA_W-1:0]      cfg_pwdata,
  output logic [cfd_pkg::CFG_DATA_W-1:0]      cfg_prdata,
  output logic                                cfg_pready,
  output cfd_pkg::cfg_regs_t                  cfg_o
);
  import cfd_pkg::*;

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;
  reg_idx_t  idx;
  logic      wr_en;

  assign idx        = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_HEADER_FIRST:  cfg_nxt.header_first     = cfg_pwdata[BYTE_W-1:0];
        REG_HEADER_SECOND: cfg_nxt.header_second    = cfg_pwdata[BYTE_W-1:0];
        REG_MAX_LENGTH:    cfg_nxt.max_frame_length = cfg_pwdata[BYTE_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.header_first     <= 8'd85;
      cfg_r.header_second    <= 8'd170;
      cfg_r.max_frame_length <= 8'd128;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_HEADER_FIRST:  cfg_prdata = {{(CFG_DATA_W-BYTE_W){1'b0}}, cfg_r.header_first};
      REG_HEADER_SECOND: cfg_prdata = {{(CFG_DATA_W-BYTE_W){1'b0}}, cfg_r.header_second};
      REG_MAX_LENGTH:    cfg_prdata = {{(CFG_DATA_W-BYTE_W){1'b0}}, cfg_r.max_frame_length};
      default:           cfg_prdata = '0;
    endcase
  end

  assign cfg_o = cfg_r;

endmodule

// ===== src/cfd_parse.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_parse
// Frame parser state machine: phase, byte count, length and running sum.
// ----------------------------------------------------------------------------
module cfd_parse (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          take,
  input  logic [cfd_pkg::BYTE_W-1:0]    rx_byte,
  input  cfd_pkg::cfg_regs_t            cfg,
  output cfd_pkg::result_t              result
);
  import cfd_pkg::*;

  phase_t            phase_r, phase_nxt;
  logic [BYTE_W-1:0] taken_r, taken_nxt;
  logic [BYTE_W-1:0] length_r, length_nxt;
  logic [BYTE_W-1:0] sum_r, sum_nxt;
  logic [BYTE_W-1:0] sum_add;
  logic              len_ok;
  logic              last_byte;

  assign sum_add   = sum_r + rx_byte;
  assign len_ok    = (rx_byte >= MIN_FRAME_LENGTH) && (rx_byte <= cfg.max_frame_length);
  assign last_byte = ({1'b0, taken_r} + 9'd1) >= {1'b0, length_r};

  // next state
  always_comb begin
    phase_nxt  = phase_r;
    taken_nxt  = taken_r;
    length_nxt = length_r;
    sum_nxt    = sum_r;
    case (phase_r)
      PH_HUNT: begin
        if (rx_byte == cfg.header_first) begin
          phase_nxt = PH_HDR2;
          taken_nxt = POS_HDR2;
          sum_nxt   = rx_byte;
        end
      end
      PH_HDR2: begin
        if (rx_byte == cfg.header_second) begin
          phase_nxt = PH_LEN;
          taken_nxt = POS_LEN;
          sum_nxt   = sum_add;
        end else begin
          phase_nxt = PH_HUNT;
          taken_nxt = '0;
          sum_nxt   = '0;
        end
      end
      PH_LEN: begin
        if (len_ok) begin
          phase_nxt  = PH_DATA;
          taken_nxt  = POS_DATA;
          length_nxt = rx_byte;
          sum_nxt    = sum_add;
        end else begin
          phase_nxt = PH_HUNT;
          taken_nxt = '0;
          sum_nxt   = '0;
        end
      end
      default: begin
        if (last_byte) begin
          phase_nxt = PH_HUNT;
          taken_nxt = '0;
          sum_nxt   = '0;
        end else begin
          taken_nxt = taken_r + 8'd1;
          sum_nxt   = sum_add;
        end
      end
    endcase
  end

  // result for the byte on the input
  always_comb begin
    result.data_byte     = rx_byte;
    result.byte_position = POS_HDR1;
    result.status        = ST_IGNORED;
    case (phase_r)
      PH_HUNT: begin
        if (rx_byte == cfg.header_first) result.status = ST_BYTE;
      end
      PH_HDR2: begin
        result.byte_position = POS_HDR2;
        result.status = (rx_byte == cfg.header_second) ? ST_BYTE : ST_ABORT;
      end
      PH_LEN: begin
        result.byte_position = POS_LEN;
        result.status = len_ok ? ST_BYTE : ST_ABORT;
      end
      default: begin
        result.byte_position = taken_r;
        if (last_byte) begin
          result.status = (rx_byte == sum_r) ? ST_GOOD : ST_BAD;
        end else begin
          result.status = ST_BYTE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HUNT;
      taken_r  <= '0;
      length_r <= '0;
      sum_r    <= '0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      taken_r  <= taken_nxt;
      length_r <= length_nxt;
      sum_r    <= sum_nxt;
    end
  end

endmodule

// ===== src/control_frame_deframer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// control_frame_deframer
// Hunts for sync/length/checksum control frames in a received byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one received byte per transfer in in_tdata[7:0].
//   out_* : one result per input byte; out_tdata holds the echoed byte and
//           its position in the frame, out_tuser holds the status code
//           (ignored, frame byte, done good, done bad checksum, aborted).
//   cfg_* : APB-style port; 0x0 first sync byte, 0x4 second sync byte,
//           0x8 maximum frame length. pready is always high.
// Output: a result appears on out_* in the cycle after its byte is taken.
// Throughput: one byte per cycle unless the receiver stalls; parser state
//   and running checksum update per taken byte, and the output register is
//   written whenever it is empty or being drained in the same cycle.
// Reset (rst_n low, synchronous): registers return to sync bytes 0x55/0xAA
//   and maximum length 128, the parser goes back to hunting, the output
//   register empties.
// Receiver stall: the result holds on out_*; in_tready drops until it is
//   taken, so no byte is lost.
// ----------------------------------------------------------------------------
module control_frame_deframer (
  input  logic        clk,
  input  logic        rst_n,
  // input byte stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] rx_byte
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [7:0] data_byte, [15:8] byte_position
  output logic [2:0]  out_tuser,   // [2:0] status
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import cfd_pkg::*;

  cfg_regs_t cfg;
  result_t   result;
  result_t   out_r;
  logic      out_valid_r;
  logic      take;

  cfd_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg_o       (cfg)
  );

  // input accepted whenever the result register is free or draining
  assign in_tready = !out_valid_r || out_tready;
  assign take      = in_tvalid && in_tready;

  cfd_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .rx_byte (in_tdata),
    .cfg     (cfg),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_r.byte_position, out_r.data_byte};
  assign out_tuser  = out_r.status;

endmodule

// ===== src/cfd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cfd_checker
// Port-level checks for the control frame deframer, bound to the top level.
// ----------------------------------------------------------------------------
module cfd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic [2:0]  out_tuser
);
  import cfd_pkg::*;

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // every accepted byte produces a result in the next cycle
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted byte gave no result");

  // ignored bytes report position zero
  a_ignored_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_IGNORED) |-> (out_tdata[15:8] == 8'd0))
    else $error("ignored byte with nonzero position");

  // an abort only happens on the second sync byte or the length byte
  a_abort_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_ABORT) |->
      (out_tdata[15:8] == POS_HDR2) || (out_tdata[15:8] == POS_LEN))
    else $error("abort at unexpected position");

  // a frame can only end past the header and length bytes
  a_done_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && ((out_tuser == ST_GOOD) || (out_tuser == ST_BAD)) |->
      (out_tdata[15:8] >= POS_DATA))
    else $error("frame end inside header");

endmodule

bind control_frame_deframer cfd_checker u_cfd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== test/control_frame_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// control_frame_deframer_tb
// Self-checking bench for the control frame deframer. A short table of probe
// bytes covers sync, length and checksum handling. Random frames and noise
// are then sent under six register settings, with a receiver stall and idle
// gaps on both streams. Every result is compared against a behavioral parser
// that runs in step with the accepted input bytes.
// ----------------------------------------------------------------------------
module control_frame_deframer_tb;
  import cfd_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;     // [7:0] rx_byte
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;    // [7:0] data_byte, [15:8] byte_position
  logic [2:0]  out_tuser;    // [2:0] status
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  control_frame_deframer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #5 clk = ~clk;

  // parser copy: registers and frame state
  logic [7:0] sync_a;
  logic [7:0] sync_b;
  logic [7:0] len_limit;
  phase_t     hunt_phase;
  logic [7:0] taken_cnt;
  logic [7:0] frame_len;
  logic [7:0] frame_sum;

  result_t     expected_results[$];
  int unsigned mismatch_count;
  int unsigned frame_items;
  bit          idle_en;
  int unsigned hold_off_len;

  // probe table for the directed part
  typedef struct {
    logic [7:0] rx;
    bit         known;
    logic [7:0] pos;
    status_t    st;
  } probe_row_t;

  probe_row_t probe_rows [20] = '{
    '{8'h00, 1'b1, 8'd0, ST_IGNORED},  // noise while hunting
    '{8'hFF, 1'b1, 8'd0, ST_IGNORED},
    '{8'h55, 1'b1, 8'd0, ST_BYTE},
    '{8'h55, 1'b1, 8'd1, ST_ABORT},    // bad second sync, not retried as first
    '{8'h55, 1'b1, 8'd0, ST_BYTE},
    '{8'hAA, 1'b1, 8'd1, ST_BYTE},
    '{8'h04, 1'b1, 8'd2, ST_ABORT},    // length below minimum
    '{8'h55, 1'b1, 8'd0, ST_BYTE},
    '{8'hAA, 1'b1, 8'd1, ST_BYTE},
    '{8'h81, 1'b1, 8'd2, ST_ABORT},    // length above maximum
    '{8'h55, 1'b1, 8'd0, ST_BYTE},     // shortest frame, good checksum
    '{8'hAA, 1'b1, 8'd1, ST_BYTE},
    '{8'h05, 1'b1, 8'd2, ST_BYTE},
    '{8'h10, 1'b1, 8'd3, ST_BYTE},
    '{8'h14, 1'b0, 8'd0, ST_IGNORED},
    '{8'h55, 1'b1, 8'd0, ST_BYTE},     // shortest frame, bad checksum
    '{8'hAA, 1'b1, 8'd1, ST_BYTE},
    '{8'h05, 1'b1, 8'd2, ST_BYTE},
    '{8'h00, 1'b1, 8'd3, ST_BYTE},
    '{8'h00, 1'b0, 8'd0, ST_IGNORED}
  };

  // register settings per phase: first sync, second sync, max length
  logic [7:0] phase_cfg [6][3] = '{
    '{8'h55, 8'hAA, 8'd128},
    '{8'h00, 8'hFF, 8'd255},
    '{8'hFF, 8'h00, 8'd5},
    '{8'h7E, 8'h7E, 8'd4},
    '{8'h3C, 8'hC3, 8'd0},
    '{8'h00, 8'h00, 8'd0}
  };

  task automatic flag_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  task automatic rewind_hunt();
    hunt_phase = PH_HUNT;
    taken_cnt  = 8'd0;
    frame_sum  = 8'd0;
  endtask

  // one byte through the parser copy
  task automatic parse_byte(input logic [7:0] b, output result_t r);
    r.data_byte     = b;
    r.byte_position = POS_HDR1;
    r.status        = ST_IGNORED;
    case (hunt_phase)
      PH_HUNT: begin
        if (b == sync_a) begin
          r.status   = ST_BYTE;
          frame_sum  = b;
          taken_cnt  = 8'd1;
          hunt_phase = PH_HDR2;
        end
      end
      PH_HDR2: begin
        r.byte_position = POS_HDR2;
        if (b == sync_b) begin
          r.status   = ST_BYTE;
          frame_sum  = frame_sum + b;
          taken_cnt  = 8'd2;
          hunt_phase = PH_LEN;
        end else begin
          r.status = ST_ABORT;
          rewind_hunt();
        end
      end
      PH_LEN: begin
        r.byte_position = POS_LEN;
        if (b < MIN_FRAME_LENGTH || b > len_limit) begin
          r.status = ST_ABORT;
          rewind_hunt();
        end else begin
          r.status   = ST_BYTE;
          frame_len  = b;
          frame_sum  = frame_sum + b;
          taken_cnt  = 8'd3;
          hunt_phase = PH_DATA;
        end
      end
      default: begin
        r.byte_position = taken_cnt;
        if ({1'b0, taken_cnt} + 9'd1 >= {1'b0, frame_len}) begin
          r.status = (b == frame_sum) ? ST_GOOD : ST_BAD;
          rewind_hunt();
        end else begin
          r.status  = ST_BYTE;
          frame_sum = frame_sum + b;
          taken_cnt = taken_cnt + 8'd1;
        end
      end
    endcase
  endtask

  // offer one byte, wait for the transfer, queue what it must produce
  task automatic send_byte(input logic [7:0] b, input bit known, input result_t typed);
    result_t pred;
    while (idle_en && $urandom_range(99) < 8) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(negedge clk);
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    parse_byte(b, pred);
    if (pred.status != ST_IGNORED) frame_items++;
    expected_results.push_back(known ? typed : pred);
  endtask

  // stop offering and wait until every result has been taken
  task automatic drain();
    in_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write: setup, access, then idle with psel low
  task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= {24'($urandom()), val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    while (!cfg_pready) @(negedge clk);
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    case (idx)
      REG_HEADER_FIRST:  sync_a    = val;
      REG_HEADER_SECOND: sync_b    = val;
      REG_MAX_LENGTH:    len_limit = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // one random stretch: mostly well-formed frames, some broken ones and noise
  task automatic send_burst(input bit full_length);
    logic [7:0]  seq[$];
    logic [7:0]  sum;
    logic [7:0]  len;
    int unsigned cap;
    int unsigned kind;
    result_t     none;
    none = '0;
    cap  = (len_limit < MIN_FRAME_LENGTH) ? 12 : len_limit;
    kind = full_length ? 0 : $urandom_range(99);
    if (kind < 70) begin
      if (full_length) len = 8'(cap);
      else if ($urandom_range(9) == 0) len = 8'($urandom_range(5, cap));
      else len = 8'($urandom_range(5, (cap < 12) ? cap : 12));
      seq = '{sync_a, sync_b, len};
      for (int i = 3; i < len - 1; i++) seq.push_back(8'($urandom_range(255)));
      sum = '0;
      foreach (seq[i]) sum += seq[i];
      if ($urandom_range(4) == 0) sum ^= 8'($urandom_range(1, 255));
      seq.push_back(sum);
    end else if (kind < 80) begin
      seq = '{sync_a, 8'($urandom_range(255))};
    end else if (kind < 88) begin
      if (len_limit == 8'd255 || $urandom_range(1) == 0) len = 8'($urandom_range(4));
      else len = 8'($urandom_range(len_limit + 1, 255));
      seq = '{sync_a, sync_b, len};
    end else begin
      repeat ($urandom_range(1, 4)) seq.push_back(8'($urandom_range(255)));
    end
    foreach (seq[i]) send_byte(seq[i], 1'b0, none);
  endtask

  // result side: ready with random stalls and one long hold-off on request
  initial begin
    int unsigned n;
    forever begin
      @(posedge clk);
      if (hold_off_len != 0) begin
        n = hold_off_len;
        hold_off_len = 0;
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= !(idle_en && $urandom_range(99) < 8);
    end
  end

  // compare every result transfer with the oldest expectation
  initial begin
    result_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          flag_mismatch("unexpected result, data_byte", out_tdata[7:0], 0);
        end else begin
          want = expected_results.pop_front();
          if (out_tdata[7:0] !== want.data_byte)
            flag_mismatch("data_byte", out_tdata[7:0], want.data_byte);
          if (out_tdata[15:8] !== want.byte_position)
            flag_mismatch("byte_position", out_tdata[15:8], want.byte_position);
          if (out_tuser !== want.status)
            flag_mismatch("status", out_tuser, want.status);
        end
      end
    end
  end

  // run limit
  initial begin
    #(2_000_000);
    $display("TB_ERROR");
    $finish;
  end

  // main sequence
  initial begin
    result_t typed;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    out_tready  = 1'b0;
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b0;
    cfg_paddr   = '0;
    cfg_pwdata  = '0;
    mismatch_count = 0;
    frame_items    = 0;
    hold_off_len   = 0;
    idle_en        = 1'b1;
    sync_a    = 8'h55;
    sync_b    = 8'hAA;
    len_limit = 8'd128;
    frame_len = 8'd0;
    rewind_hunt();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed probes at reset settings
    foreach (probe_rows[i]) begin
      typed.data_byte     = probe_rows[i].rx;
      typed.byte_position = probe_rows[i].pos;
      typed.status        = probe_rows[i].st;
      send_byte(probe_rows[i].rx, probe_rows[i].known, typed);
    end

    // random phases, one register setting each
    phase_cfg[5] = '{8'($urandom_range(255)), 8'($urandom_range(255)),
                     8'($urandom_range(5, 255))};
    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(REG_HEADER_FIRST, phase_cfg[p][0]);
      write_reg(REG_HEADER_SECOND, phase_cfg[p][1]);
      write_reg(REG_MAX_LENGTH, phase_cfg[p][2]);
      if (p == 4) write_reg(REG_UNUSED, 8'($urandom_range(255)));
      idle_en = (p != 1);
      if (p == 2) hold_off_len = 300;
      frame_items = 0;
      if (p == 1) send_burst(1'b1);
      while (frame_items < 20) begin
        send_burst(1'b0);
        if ($urandom_range(19) == 0) drain();
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (expected_results.size() != 0)
      flag_mismatch("results still missing", 0, expected_results.size());
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/cfd_pkg.sv
src/cfd_regs.sv
src/cfd_parse.sv
src/control_frame_deframer.sv
src/cfd_checker.sv
test/control_frame_deframer_tb.sv
